// File: design/icv_pkg.sv
// shared constants and types for the streaming kxk image convolution block
package icv_pkg;

    localparam int DEF_MAX_COLS   = 1024;
    localparam int DEF_MAX_KERNEL = 7;
    localparam int MAX_ROWS       = 4096;

    localparam int COLS_W  = 11;
    localparam int ROWS_W  = 13;
    localparam int KSIZE_W = 3;
    localparam int SCALE_W = 24;
    localparam int CFG_W   = 24;
    localparam int IDX_W   = 2;

    localparam logic [COLS_W-1:0]  RST_COLS  = 11'd640;
    localparam logic [ROWS_W-1:0]  RST_ROWS  = 13'd480;
    localparam logic [KSIZE_W-1:0] RST_KSIZE = 3'd3;
    localparam logic [SCALE_W-1:0] RST_SCALE = 24'd65536;

    typedef enum logic [1:0] {
        OP_TAP   = 2'd0,
        OP_PIXEL = 2'd1,
        OP_FLUSH = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    typedef enum logic [IDX_W-1:0] {
        REG_COLS  = 2'd0,
        REG_ROWS  = 2'd1,
        REG_KSIZE = 2'd2,
        REG_SCALE = 2'd3
    } t_reg_idx;

endpackage

// File: design/icv_in_if.sv
// input request channel: tap loads, pixels and flushes
interface icv_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic [5:0]         tap_index;
    logic signed [15:0] tap_value;
    logic signed [15:0] pixel;

    modport source (output valid, opcode, tap_index, tap_value, pixel, input ready);
    modport sink   (input valid, opcode, tap_index, tap_value, pixel, output ready);
endinterface

// File: design/icv_out_if.sv
// output request channel: filtered or passed-through pixels
interface icv_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_pixel;
    logic [11:0]        out_row;
    logic [9:0]         out_col;
    logic               is_border;
    logic               frame_last;

    modport source (output valid, result_pixel, out_row, out_col, is_border, frame_last,
                    input ready);
    modport sink   (input valid, result_pixel, out_row, out_col, is_border, frame_last,
                    output ready);
endinterface

// File: design/icv_ram.sv
// generic single-port-write, single-port-read ram with registered read data
module icv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: design/image_convolution_2d_top.sv
// Streaming KxK convolution over a raster pixel stream. Pixels go into a ring
// line store of MAX_KERNEL*MAX_COLS+MAX_KERNEL entries, taps into a small tap
// memory. One item is taken at a time. A border result passes the centre pixel
// through. For an interior result the window is walked one tap per cycle
// through the single read port of the line store, then the sum is scaled in two
// partial products and saturated. A result waits in an output register while
// the next item is taken.
module image_convolution_2d_top #(
    parameter int MAX_COLS   = icv_pkg::DEF_MAX_COLS,
    parameter int MAX_KERNEL = icv_pkg::DEF_MAX_KERNEL
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    icv_in_if.sink                      i_in,
    icv_out_if.source                   o_out,
    input  logic                        i_cfg_we,
    input  logic [icv_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [icv_pkg::CFG_W-1:0]   i_cfg_data
);
    import icv_pkg::*;

    localparam int RING = MAX_KERNEL * MAX_COLS + MAX_KERNEL;
    localparam int RW   = $clog2(RING);
    localparam int TAPS = MAX_KERNEL * MAX_KERNEL;
    localparam int TW   = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int CW   = $clog2(MAX_COLS);
    localparam int KW   = $clog2(MAX_KERNEL + 1);
    localparam int AW   = 33 + $clog2(TAPS + 1);
    localparam int LO   = AW / 2;
    localparam int HI   = AW - LO;
    localparam int FW   = AW + SCALE_W + 1;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_PREP  = 11'b000_0000_0010,
        S_PREP2 = 11'b000_0000_0100,
        S_WIN   = 11'b000_0000_1000,
        S_WAIT  = 11'b000_0001_0000,
        S_BRD   = 11'b000_0010_0000,
        S_BRDW  = 11'b000_0100_0000,
        S_SC1   = 11'b000_1000_0000,
        S_SC2   = 11'b001_0000_0000,
        S_SC3   = 11'b010_0000_0000,
        S_DONE  = 11'b100_0000_0000
    } t_state;

    t_state r_state;

    logic [COLS_W-1:0]         r_cfg_cols;
    logic [ROWS_W-1:0]         r_cfg_rows;
    logic [KSIZE_W-1:0]        r_cfg_k;
    logic signed [SCALE_W-1:0] r_scale;

    logic [RW-1:0]  r_wr_ptr, r_pend, r_pos, r_addr, r_row_addr;
    logic [11:0]    r_orow;
    logic [CW-1:0]  r_ocol;
    logic [KW-1:0]  r_i, r_j;
    logic [TW-1:0]  r_tidx;
    logic [TAPS-1:0] r_tap_vld;
    logic           r_v1, r_v2, r_l1, r_l2, r_tv1;
    logic signed [31:0]          r_prod;
    logic signed [AW-1:0]        r_acc;
    logic signed [LO+SCALE_W:0]  r_plo;
    logic signed [HI+SCALE_W-1:0] r_phi;
    logic signed [31:0]          r_res;
    logic [11:0]    r_g_row;
    logic [CW-1:0]  r_g_col;
    logic           r_g_brd, r_g_last;
    logic           r_ovld;
    logic signed [31:0] r_o_res;
    logic [11:0]    r_o_row;
    logic [9:0]     r_o_col;
    logic           r_o_brd, r_o_last;

    logic [CW:0]        cols_e;
    logic [ROWS_W-1:0]  rows_e;
    logic [KW-1:0]      k_e, h;
    logic [RW-1:0]      d_val, pos_c, start_c, n_wr_ptr, n_addr_inc;
    logic [RW:0]        row_sum;
    logic [RW-1:0]      n_row_addr;
    logic               accept, win_last, border_c;
    logic [15:0]        line_rd, tap_rd;
    logic               pix_we, tap_we;
    logic [TW-1:0]      tap_waddr;
    logic signed [FW-1:0] full;
    logic signed [AW-1:0] shd;
    logic signed [31:0]   sat_c;

    always_comb begin
        if (r_cfg_cols == '0) begin
            cols_e = (CW+1)'(1);
        end else if (32'(r_cfg_cols) > MAX_COLS) begin
            cols_e = (CW+1)'(MAX_COLS);
        end else begin
            cols_e = (CW+1)'(r_cfg_cols);
        end
        if (r_cfg_rows == '0) begin
            rows_e = ROWS_W'(1);
        end else if (32'(r_cfg_rows) > MAX_ROWS) begin
            rows_e = ROWS_W'(MAX_ROWS);
        end else begin
            rows_e = r_cfg_rows;
        end
        if (r_cfg_k == '0) begin
            k_e = KW'(1);
        end else if (32'(r_cfg_k) > MAX_KERNEL) begin
            k_e = KW'(MAX_KERNEL);
        end else begin
            k_e = KW'(r_cfg_k);
        end
    end

    assign h       = k_e >> 1;
    assign d_val   = RW'(32'(h) * 32'(cols_e) + 32'(h));
    assign pos_c   = r_wr_ptr - r_pend + ((r_wr_ptr >= r_pend) ? RW'(0) : RW'(RING));
    assign start_c = r_pos - d_val + ((r_pos >= d_val) ? RW'(0) : RW'(RING));
    assign n_wr_ptr   = (r_wr_ptr == RW'(RING - 1)) ? '0 : r_wr_ptr + RW'(1);
    assign n_addr_inc = (r_addr == RW'(RING - 1)) ? '0 : r_addr + RW'(1);
    assign row_sum    = (RW+1)'(r_row_addr) + (RW+1)'(cols_e);
    assign n_row_addr = (row_sum >= (RW+1)'(RING)) ? RW'(row_sum - (RW+1)'(RING))
                                                   : RW'(row_sum);
    assign win_last   = (r_i == k_e - KW'(1)) && (r_j == k_e - KW'(1));
    assign border_c   = !((14'(r_orow) >= 14'(h)) && (14'(r_orow) + 14'(h) < 14'(rows_e)) &&
                          (14'(r_ocol) >= 14'(h)) && (14'(r_ocol) + 14'(h) < 14'(cols_e)));

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign pix_we     = accept && (i_in.opcode == OP_PIXEL);
    assign tap_we     = accept && (i_in.opcode == OP_TAP) && (32'(i_in.tap_index) < TAPS);
    assign tap_waddr  = TW'(i_in.tap_index);

    icv_ram #(.WIDTH(16), .DEPTH(RING), .AW(RW)) u_line (
        .i_clk   (i_clk),
        .i_we    (pix_we),
        .i_waddr (r_wr_ptr),
        .i_wdata (i_in.pixel),
        .i_raddr (r_addr),
        .o_rdata (line_rd)
    );

    icv_ram #(.WIDTH(16), .DEPTH(TAPS), .AW(TW)) u_taps (
        .i_clk   (i_clk),
        .i_we    (tap_we),
        .i_waddr (tap_waddr),
        .i_wdata (i_in.tap_value),
        .i_raddr (r_tidx),
        .o_rdata (tap_rd)
    );

    always_comb begin
        full = (FW'(r_phi) <<< LO) + FW'(r_plo);
        shd  = AW'(full >>> 24);
        if (shd[AW-1] && !(&shd[AW-1:31])) begin
            sat_c = 32'sh8000_0000;
        end else if (!shd[AW-1] && (|shd[AW-1:31])) begin
            sat_c = 32'sh7fff_ffff;
        end else begin
            sat_c = shd[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_v1   <= (r_state == S_WIN);
        r_l1   <= (r_state == S_WIN) && win_last;
        r_tv1  <= r_tap_vld[r_tidx];
        r_v2   <= r_v1;
        r_l2   <= r_l1;
        r_prod <= $signed(line_rd) * (r_tv1 ? $signed(tap_rd) : 16'sd0);
        if (r_state == S_PREP) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + AW'(r_prod);
        end
        if (r_state == S_SC1) begin
            r_plo <= $signed({1'b0, r_acc[LO-1:0]}) * r_scale;
        end
        if (r_state == S_SC2) begin
            r_phi <= $signed(r_acc[AW-1:LO]) * r_scale;
        end
        if (r_state == S_SC3) begin
            r_res <= sat_c;
        end else if (r_state == S_BRDW) begin
            r_res <= 32'(signed'(line_rd));
        end
        if (r_state == S_PREP) begin
            r_pos    <= pos_c;
            r_g_row  <= r_orow;
            r_g_col  <= r_ocol;
            r_g_brd  <= border_c;
            r_g_last <= (13'(r_orow) + 13'd1 == rows_e) && ((CW+1)'(r_ocol) + 1'b1 == cols_e);
        end
        if (r_state == S_DONE && (!r_ovld || o_out.ready)) begin
            r_o_res  <= r_res;
            r_o_row  <= r_g_row;
            r_o_col  <= 10'(r_g_col);
            r_o_brd  <= r_g_brd;
            r_o_last <= r_g_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cfg_cols <= RST_COLS;
            r_cfg_rows <= RST_ROWS;
            r_cfg_k    <= RST_KSIZE;
            r_scale    <= RST_SCALE;
            r_wr_ptr   <= '0;
            r_pend     <= '0;
            r_orow     <= '0;
            r_ocol     <= '0;
            r_tap_vld  <= '0;
            r_ovld     <= 1'b0;
            r_addr     <= '0;
            r_row_addr <= '0;
            r_i        <= '0;
            r_j        <= '0;
            r_tidx     <= '0;
        end else begin
            if (r_ovld && o_out.ready && (r_state != S_DONE)) begin
                r_ovld <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_idx))
                    REG_COLS:  r_cfg_cols <= COLS_W'(i_cfg_data);
                    REG_ROWS:  r_cfg_rows <= ROWS_W'(i_cfg_data);
                    REG_KSIZE: r_cfg_k    <= KSIZE_W'(i_cfg_data);
                    REG_SCALE: r_scale    <= i_cfg_data;
                endcase
                if (t_reg_idx'(i_cfg_idx) != REG_SCALE) begin
                    r_wr_ptr <= '0;
                    r_pend   <= '0;
                    r_orow   <= '0;
                    r_ocol   <= '0;
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        unique case (t_opcode'(i_in.opcode))
                            OP_TAP: begin
                                if (tap_we) begin
                                    r_tap_vld[tap_waddr] <= 1'b1;
                                end
                            end
                            OP_PIXEL: begin
                                r_wr_ptr <= n_wr_ptr;
                                r_pend   <= r_pend + RW'(1);
                                if (r_pend + RW'(1) > d_val) begin
                                    r_state <= S_PREP;
                                end
                            end
                            OP_FLUSH: begin
                                if (r_pend != '0) begin
                                    r_state <= S_PREP;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_PREP: r_state <= S_PREP2;
                S_PREP2: begin
                    r_i    <= '0;
                    r_j    <= '0;
                    r_tidx <= '0;
                    if (r_g_brd) begin
                        r_addr  <= r_pos;
                        r_state <= S_BRD;
                    end else begin
                        r_addr     <= start_c;
                        r_row_addr <= start_c;
                        r_state    <= S_WIN;
                    end
                end
                S_WIN: begin
                    r_tidx <= r_tidx + TW'(1);
                    if (win_last) begin
                        r_state <= S_WAIT;
                    end else if (r_j == k_e - KW'(1)) begin
                        r_j        <= '0;
                        r_i        <= r_i + KW'(1);
                        r_addr     <= n_row_addr;
                        r_row_addr <= n_row_addr;
                    end else begin
                        r_j    <= r_j + KW'(1);
                        r_addr <= n_addr_inc;
                    end
                end
                S_WAIT: begin
                    if (r_l2) begin
                        r_state <= S_SC1;
                    end
                end
                S_BRD:  r_state <= S_BRDW;
                S_BRDW: r_state <= S_DONE;
                S_SC1:  r_state <= S_SC2;
                S_SC2:  r_state <= S_SC3;
                S_SC3:  r_state <= S_DONE;
                S_DONE: begin
                    if (!r_ovld || o_out.ready) begin
                        r_ovld  <= 1'b1;
                        r_pend  <= r_pend - RW'(1);
                        r_state <= S_IDLE;
                        if ((CW+1)'(r_ocol) + 1'b1 >= cols_e) begin
                            r_ocol <= '0;
                            r_orow <= (13'(r_orow) + 13'd1 >= rows_e) ? '0 : r_orow + 12'd1;
                        end else begin
                            r_ocol <= r_ocol + CW'(1);
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid        = r_ovld;
    assign o_out.result_pixel = r_o_res;
    assign o_out.out_row      = r_o_row;
    assign o_out.out_col      = r_o_col;
    assign o_out.is_border    = r_o_brd;
    assign o_out.frame_last   = r_o_last;

    a_pend_on_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PREP) |-> (r_pend != '0))
        else $error("emit started with nothing pending");

    a_wr_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_wr_ptr) < RING))
        else $error("line store write pointer out of range");

    a_mac_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> ((r_state == S_WIN) || (r_state == S_WAIT)))
        else $error("window accumulate outside window walk");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovld) |-> $past(r_state == S_DONE))
        else $error("output loaded outside done state");
endmodule

// File: bench/image_convolution_2d_top_test.sv
// self-checking testbench for the streaming kxk image convolution block
module image_convolution_2d_top_test;
    import icv_pkg::*;

    localparam int RING_LEN = DEF_MAX_COLS * DEF_MAX_KERNEL + DEF_MAX_KERNEL;
    localparam int NUM_TAPS = DEF_MAX_KERNEL * DEF_MAX_KERNEL;
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct {
        logic [1:0]         op;
        logic [5:0]         tap_idx;
        logic signed [15:0] tap_val;
        logic signed [15:0] pix;
    } t_request;

    typedef struct {
        logic signed [31:0] value;
        logic [11:0]        row;
        logic [9:0]         col;
        logic               border;
        logic               last;
    } t_out_pixel;

    logic                i_clk;
    logic                i_rst_n;
    logic                cfg_we;
    logic [IDX_W-1:0]    cfg_idx;
    logic [CFG_W-1:0]    cfg_data;

    icv_in_if  in_ch ();
    icv_out_if out_ch ();

    image_convolution_2d_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // convolution predictor state
    shortint     tap_mem [NUM_TAPS];
    shortint     line_mem [RING_LEN];
    int unsigned geo_cols, geo_rows, geo_k;
    int          coef_scale;
    int unsigned wr_ptr, backlog, out_r, out_c;

    t_request    request_q[$];
    t_out_pixel  pixel_expect_q[$];
    bit          took;
    bit          calm;
    int          errors;
    int          cycles;
    int          accepted_items;
    int          checked_pixels;
    int          interior_pixels;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("image_convolution_2d_top_test failed");
            $finish;
        end
    end

    function automatic int unsigned cols_eff();
        if (geo_cols == 0) return 1;
        return (geo_cols > DEF_MAX_COLS) ? DEF_MAX_COLS : geo_cols;
    endfunction

    function automatic int unsigned rows_eff();
        if (geo_rows == 0) return 1;
        return (geo_rows > MAX_ROWS) ? MAX_ROWS : geo_rows;
    endfunction

    function automatic int unsigned k_eff();
        if (geo_k == 0) return 1;
        return (geo_k > DEF_MAX_KERNEL) ? DEF_MAX_KERNEL : geo_k;
    endfunction

    task automatic restart_stream();
        wr_ptr = 0;
        backlog = 0;
        out_r = 0;
        out_c = 0;
    endtask

    task automatic emit_pixel();
        int unsigned cols, rows, k, h, pos, idx, r, c;
        int          off;
        longint      acc, prod, sh;
        t_out_pixel  e;
        cols = cols_eff();
        rows = rows_eff();
        k = k_eff();
        h = k / 2;
        pos = (wr_ptr + RING_LEN - backlog) % RING_LEN;
        r = out_r;
        c = out_c;
        e.border = !(r >= h && r + h < rows && c >= h && c + h < cols);
        if (e.border) begin
            e.value = 32'(int'(line_mem[pos]));
        end else begin
            acc = 0;
            for (int i = 0; i < k; i++) begin
                for (int j = 0; j < k; j++) begin
                    off = (i - int'(h)) * int'(cols) + (j - int'(h));
                    idx = (int'(pos) + RING_LEN + off) % RING_LEN;
                    acc += longint'(line_mem[idx]) * longint'(tap_mem[i * k + j]);
                end
            end
            prod = acc * longint'(coef_scale);
            sh = prod >>> 24;
            if (sh > 64'sd2147483647) sh = 64'sd2147483647;
            if (sh < -64'sd2147483648) sh = -64'sd2147483648;
            e.value = 32'(sh);
            interior_pixels++;
        end
        e.row = 12'(r);
        e.col = 10'(c);
        e.last = (r + 1 == rows && c + 1 == cols);
        pixel_expect_q.push_back(e);
        backlog--;
        out_c++;
        if (out_c >= cols) begin
            out_c = 0;
            out_r++;
            if (out_r >= rows) out_r = 0;
        end
    endtask

    task automatic predict_request(t_request rq);
        int unsigned h;
        case (rq.op)
            OP_TAP: begin
                if (rq.tap_idx < NUM_TAPS) tap_mem[rq.tap_idx] = rq.tap_val;
            end
            OP_PIXEL: begin
                h = k_eff() / 2;
                line_mem[wr_ptr] = rq.pix;
                wr_ptr = (wr_ptr + 1) % RING_LEN;
                backlog++;
                if (backlog > h * cols_eff() + h) emit_pixel();
            end
            OP_FLUSH: begin
                if (backlog > 0) emit_pixel();
            end
            default: ;
        endcase
    endtask

    task automatic report_bad(string what);
        $display("mismatch at cycle %0d: %s", cycles, what);
        errors++;
    endtask

    // input driver
    always @(negedge i_clk) begin
        t_request rq;
        if (took || !in_ch.valid) begin
            if (request_q.size() > 0 && (calm || $urandom_range(99) >= 6)) begin
                rq = request_q.pop_front();
                in_ch.opcode    <= rq.op;
                in_ch.tap_index <= rq.tap_idx;
                in_ch.tap_value <= rq.tap_val;
                in_ch.pixel     <= rq.pix;
                in_ch.valid     <= 1'b1;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
        out_ch.ready <= calm || ($urandom_range(99) >= 6);
    end

    // acceptance and result monitor
    always @(posedge i_clk) begin
        t_request   rq;
        t_out_pixel e;
        took = i_rst_n && in_ch.valid && in_ch.ready;
        if (took) begin
            rq.op = in_ch.opcode;
            rq.tap_idx = in_ch.tap_index;
            rq.tap_val = in_ch.tap_value;
            rq.pix = in_ch.pixel;
            predict_request(rq);
            accepted_items++;
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pixel_expect_q.size() == 0) begin
                report_bad($sformatf("unexpected result %0d", out_ch.result_pixel));
            end else begin
                e = pixel_expect_q.pop_front();
                checked_pixels++;
                if (out_ch.result_pixel !== e.value)
                    report_bad($sformatf("result_pixel %0d want %0d at (%0d,%0d)",
                        out_ch.result_pixel, e.value, e.row, e.col));
                if (out_ch.out_row !== e.row)
                    report_bad($sformatf("out_row %0d want %0d", out_ch.out_row, e.row));
                if (out_ch.out_col !== e.col)
                    report_bad($sformatf("out_col %0d want %0d", out_ch.out_col, e.col));
                if (out_ch.is_border !== e.border)
                    report_bad($sformatf("is_border %0b want %0b at (%0d,%0d)",
                        out_ch.is_border, e.border, e.row, e.col));
                if (out_ch.frame_last !== e.last)
                    report_bad($sformatf("frame_last %0b want %0b at (%0d,%0d)",
                        out_ch.frame_last, e.last, e.row, e.col));
            end
        end
    end

    task automatic wait_drained();
        do begin
            @(posedge i_clk);
            #1;
        end while (request_q.size() != 0 || in_ch.valid || pixel_expect_q.size() != 0);
        repeat (150) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [CFG_W-1:0] d);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= d;
        case (idx)
            REG_COLS:  begin geo_cols = d[COLS_W-1:0]; restart_stream(); end
            REG_ROWS:  begin geo_rows = d[ROWS_W-1:0]; restart_stream(); end
            REG_KSIZE: begin geo_k = d[KSIZE_W-1:0]; restart_stream(); end
            default:   coef_scale = int'($signed(d));
        endcase
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_req(logic [1:0] op, logic signed [15:0] pix);
        t_request rq;
        rq.op = op;
        rq.tap_idx = 6'($urandom);
        rq.tap_val = 16'($urandom);
        rq.pix = pix;
        request_q.push_back(rq);
    endtask

    task automatic push_tap(int idx, logic signed [15:0] val);
        t_request rq;
        rq.op = OP_TAP;
        rq.tap_idx = 6'(idx);
        rq.tap_val = val;
        rq.pix = 16'($urandom);
        request_q.push_back(rq);
    endtask

    function automatic logic signed [15:0] pick_pixel();
        case ($urandom_range(9))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        int unsigned c, r, k, h, nf, lag;
        int          rand_items, phase;
        logic [CFG_W-1:0] sc;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.opcode = '0;
        in_ch.tap_index = '0;
        in_ch.tap_value = '0;
        in_ch.pixel = '0;
        out_ch.ready = 1'b0;
        took = 0;
        calm = 0;
        errors = 0;
        cycles = 0;
        accepted_items = 0;
        checked_pixels = 0;
        interior_pixels = 0;
        foreach (tap_mem[i]) tap_mem[i] = 0;
        foreach (line_mem[i]) line_mem[i] = 0;
        geo_cols = RST_COLS;
        geo_rows = RST_ROWS;
        geo_k = RST_KSIZE;
        coef_scale = int'($signed(RST_SCALE));
        restart_stream();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        repeat (3) @(posedge i_clk);

        // prime the low part of the line store with a tall single-column frame
        write_reg(REG_KSIZE, 24'd0);
        write_reg(REG_COLS, 24'd1);
        write_reg(REG_ROWS, 24'd4096);
        for (int i = 0; i < 200; i++) push_req(OP_PIXEL, pick_pixel());
        wait_drained();
        // clamped geometry drained early by flushes
        write_reg(REG_COLS, 24'd2047);
        write_reg(REG_ROWS, 24'd0);
        write_reg(REG_KSIZE, 24'd7);
        calm = 1;
        for (int i = 0; i < 40; i++) push_req(OP_PIXEL, pick_pixel());
        for (int i = 0; i < 42; i++) push_req(OP_FLUSH, 16'($urandom));
        wait_drained();
        calm = 0;

        // directed: saturating taps and pixels, ignored items, idle flush
        write_reg(REG_COLS, 24'd4);
        write_reg(REG_ROWS, 24'd4);
        write_reg(REG_KSIZE, 24'd3);
        write_reg(REG_SCALE, 24'h7fffff);
        for (int i = 0; i < 9; i++) push_tap(i, (i % 2) ? 16'sh8000 : 16'sh7fff);
        push_tap(63, 16'sh1234);
        push_tap(49, 16'sh4321);
        push_req(OP_NONE, 16'sh7fff);
        push_req(OP_FLUSH, 16'sh0);
        for (int i = 0; i < 16; i++) push_req(OP_PIXEL, (i % 3) ? 16'sh7fff : 16'sh8000);
        for (int i = 0; i < 6; i++) push_req(OP_FLUSH, 16'sh0);
        wait_drained();

        // random frames with random geometry, taps and scale
        rand_items = 0;
        phase = 0;
        while (rand_items < 430) begin
            c = $urandom_range(1, 10);
            r = $urandom_range(1, 8);
            k = $urandom_range(0, 7);
            write_reg(REG_COLS, {13'($urandom), 11'(c)});
            write_reg(REG_ROWS, {11'($urandom), 13'(r)});
            write_reg(REG_KSIZE, {21'($urandom), 3'(k)});
            case ($urandom_range(5))
                0: sc = 24'h800000;
                1: sc = 24'h7fffff;
                2: sc = 24'h010000;
                default: sc = 24'($urandom);
            endcase
            write_reg(REG_SCALE, sc);
            calm = (phase == 3);
            k = (k == 0) ? 1 : k;
            h = k / 2;
            for (int i = 0; i < k * k; i++)
                if ($urandom_range(3) != 0) push_tap(i, 16'($urandom));
            if ($urandom_range(3) == 0) push_tap($urandom_range(49, 63), 16'($urandom));
            nf = $urandom_range(1, 2);
            for (int i = 0; i < nf * c * r; i++) begin
                push_req(OP_PIXEL, pick_pixel());
                if ($urandom_range(99) < 4) push_req(OP_FLUSH, 16'($urandom));
                if ($urandom_range(99) < 3) push_req(OP_NONE, 16'($urandom));
            end
            lag = h * c + h + $urandom_range(0, 2);
            for (int i = 0; i < lag; i++) push_req(OP_FLUSH, 16'($urandom));
            rand_items += request_q.size();
            wait_drained();
            phase++;
        end
        calm = 0;

        wait_drained();
        $display("run covered %0d accepted requests and %0d checked pixels, %0d interior",
            accepted_items, checked_pixels, interior_pixels);
        $display("random part spanned %0d geometry phases, %0d mismatches", phase, errors);
        if (errors == 0 && pixel_expect_q.size() == 0) begin
            $display("image_convolution_2d_top_test passed");
        end else begin
            $display("image_convolution_2d_top_test failed");
        end
        $finish;
    end

endmodule
